// ----- design/dgcd_pkg.sv -----
// ----------------------------------------------------------------------------
// dgcd_pkg
// Shared types, command codes and helper functions of the directed graph
// cycle detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dgcd_pkg;

  // Graph size follows from the fixed 6-bit vertex fields
  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VTX_W + 1;

  typedef logic [VTX_W-1:0]        vertex_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [MAX_VERTICES-1:0] vrow_t;

  // Command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Adjacency store access request
  typedef struct packed {
    logic    rd_en;
    vertex_t rd_addr;
    logic    wr_en;
    vertex_t wr_addr;
    vrow_t   wr_data;
    logic    clear;
  } adj_req_t;

  // Search stack access request
  typedef struct packed {
    logic    rd_en;
    vertex_t rd_addr;
    logic    wr_en;
    vertex_t wr_addr;
    vertex_t wr_data;
  } stk_req_t;

  // Index of the lowest set bit; zero when no bit is set
  function automatic vertex_t lowest_bit(input vrow_t x);
    vertex_t idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (x[i]) idx = VTX_W'(i);
    end
    return idx;
  endfunction

  // One bit for every vertex below the active count
  function automatic vrow_t active_mask(input count_t n);
    vrow_t m;
    m = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/dgcd_if.sv -----
// ----------------------------------------------------------------------------
// dgcd_if
// Valid/ready channel interfaces: command items, result items and the
// configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dgcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] src_vertex;
  logic [5:0] dst_vertex;

  modport source (output valid, command, src_vertex, dst_vertex, input ready);
  modport sink   (input valid, command, src_vertex, dst_vertex, output ready);
endinterface

interface dgcd_out_if;
  logic valid;
  logic ready;
  logic status;
  logic cycle_found;

  modport source (output valid, status, cycle_found, input ready);
  modport sink   (input valid, status, cycle_found, output ready);
endinterface

interface dgcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/directed_graph_cycle_detector.sv -----
// ----------------------------------------------------------------------------
// directed_graph_cycle_detector
// Builds a directed graph in an adjacency bit matrix and reports whether the
// graph over the active vertices holds a directed cycle.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Payload                               Handshake
//  in_chan    in         command, src_vertex, dst_vertex       valid/ready
//  out_chan   out        status, cycle_found                   valid/ready
//  cfg_chan   in         data = num_vertices (7 bits)          valid/ready
//
//  Add edge passes through S_ADD_WR and S_EMIT; clear, reject and unused
//  commands go straight to S_EMIT. A check steps through the roots in S_ROOT:
//  each expansion waits in S_EXPAND on the adjacency memory read, a pop adds
//  the stack memory read in S_POPRD, and each result waits in S_EMIT for out_chan.
//  Reset (rst_n, synchronous) empties the graph at once through row valid
//  bits and sets num_vertices to 64. One item is in work at a time; a
//  result waiting on out_chan does not block acceptance of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_graph_cycle_detector
  import dgcd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  dgcd_in_if.sink    in_chan,
  dgcd_out_if.source out_chan,
  dgcd_cfg_if.sink   cfg_chan
);

  logic [6:0] num_vertices_r;
  count_t     n_act;
  vrow_t      act_mask;
  adj_req_t   adj_req;
  vrow_t      adj_row;
  stk_req_t   stk_req;
  vertex_t    stk_rd_data;

  // Configuration register, always writable
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= 7'd64;
    end else if (cfg_chan.valid) begin
      num_vertices_r <= cfg_chan.data;
    end
  end

  // Saturate the active count at the matrix size
  assign n_act    = (num_vertices_r > 7'(MAX_VERTICES)) ? count_t'(MAX_VERTICES)
                                                         : count_t'(num_vertices_r);
  assign act_mask = active_mask(n_act);

  dgcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .n_act       (n_act),
    .act_mask    (act_mask),
    .adj_req     (adj_req),
    .adj_row     (adj_row),
    .stk_req     (stk_req),
    .stk_rd_data (stk_rd_data)
  );

  dgcd_adj_store u_adj (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (adj_req),
    .rd_row (adj_row)
  );

  dgcd_stack u_stack (
    .clk     (clk),
    .req     (stk_req),
    .rd_data (stk_rd_data)
  );

endmodule

`default_nettype wire

// ----- design/dgcd_adj_store.sv -----
// ----------------------------------------------------------------------------
// dgcd_adj_store
// Adjacency bit matrix: one row per source vertex in a synchronous memory,
// with a row valid bit per row so that a clear needs no memory writes.
// ----------------------------------------------------------------------------
`default_nettype none

module dgcd_adj_store
  import dgcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire adj_req_t req,
  output vrow_t         rd_row
);

  vrow_t mem [MAX_VERTICES];
  vrow_t rd_data_r;
  vrow_t row_valid_r;
  logic  rd_valid_r;

  // Row storage, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // Track which rows hold written data since the last clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (req.clear) begin
        row_valid_r <= '0;
      end else if (req.wr_en) begin
        row_valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= row_valid_r[req.rd_addr];
      end
    end
  end

  // A row never written since the last clear reads as no edges
  assign rd_row = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ----- design/dgcd_stack.sv -----
// ----------------------------------------------------------------------------
// dgcd_stack
// Search stack of the depth-first walk: vertex entries in a synchronous
// memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dgcd_stack
  import dgcd_pkg::*;
(
  input  wire logic     clk,
  input  wire stk_req_t req,
  output vertex_t       rd_data
);

  vertex_t mem [MAX_VERTICES];
  vertex_t rd_data_r;

  // Push writes, pop reads the new top
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- design/dgcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dgcd_ctrl
// Command sequencer: edge add read-modify-write, graph clear, and the
// depth-first cycle search over the adjacency and stack memories.
// ----------------------------------------------------------------------------
`default_nettype none

module dgcd_ctrl
  import dgcd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  dgcd_in_if.sink    in_chan,
  dgcd_out_if.source out_chan,
  input  wire count_t n_act,
  input  wire vrow_t  act_mask,
  output adj_req_t   adj_req,
  input  wire vrow_t  adj_row,
  output stk_req_t   stk_req,
  input  wire vertex_t stk_rd_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_WR = 3'd1;
  localparam logic [2:0] S_ROOT   = 3'd2;
  localparam logic [2:0] S_EXPAND = 3'd3;
  localparam logic [2:0] S_POPRD  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  vrow_t      visited_r, visited_nxt;
  vrow_t      on_path_r, on_path_nxt;
  count_t     depth_r, depth_nxt;
  count_t     root_r, root_nxt;
  vertex_t    top_r, top_nxt;
  vertex_t    dst_r, dst_nxt;
  logic       res_status_r, res_status_nxt;
  logic       res_cycle_r, res_cycle_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_status_r, out_status_nxt;
  logic       out_cycle_r, out_cycle_nxt;

  logic       in_fire;
  logic       src_bad, dst_bad;
  vrow_t      row_m, fresh;
  logic       hit;
  vertex_t    nxt_v;
  vertex_t    root_v;
  logic       out_free;

  assign in_chan.ready     = (state_r == S_IDLE);
  assign in_fire           = in_chan.valid && in_chan.ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.cycle_found = out_cycle_r;

  assign src_bad  = ({1'b0, in_chan.src_vertex} >= n_act);
  assign dst_bad  = ({1'b0, in_chan.dst_vertex} >= n_act);
  assign row_m    = adj_row & act_mask;
  assign hit      = |(row_m & on_path_r);
  assign fresh    = row_m & ~visited_r;
  assign nxt_v    = lowest_bit(fresh);
  assign root_v   = root_r[VTX_W-1:0];
  assign out_free = !out_valid_r || out_chan.ready;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    visited_nxt    = visited_r;
    on_path_nxt    = on_path_r;
    depth_nxt      = depth_r;
    root_nxt       = root_r;
    top_nxt        = top_r;
    dst_nxt        = dst_r;
    res_status_nxt = res_status_r;
    res_cycle_nxt  = res_cycle_r;
    out_valid_nxt  = out_chan.ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_cycle_nxt  = out_cycle_r;
    adj_req        = '0;
    stk_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = 1'b0;
          res_cycle_nxt  = 1'b0;
          state_nxt      = S_EMIT;
          case (in_chan.command)
            CMD_ADD: begin
              if (src_bad || dst_bad) begin
                res_status_nxt = 1'b1;
              end else begin
                adj_req.rd_en   = 1'b1;
                adj_req.rd_addr = in_chan.src_vertex;
                top_nxt         = in_chan.src_vertex;
                dst_nxt         = in_chan.dst_vertex;
                state_nxt       = S_ADD_WR;
              end
            end
            CMD_CHECK: begin
              visited_nxt = '0;
              on_path_nxt = '0;
              depth_nxt   = '0;
              root_nxt    = '0;
              state_nxt   = S_ROOT;
            end
            CMD_CLEAR: begin
              adj_req.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // Merge the new edge into the fetched row
      S_ADD_WR: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = top_r;
        adj_req.wr_data = adj_row | (vrow_t'(1) << dst_r);
        state_nxt       = S_EMIT;
      end

      // Walk the roots; start a search at each unvisited one
      S_ROOT: begin
        if (root_r >= n_act) begin
          res_cycle_nxt = 1'b0;
          state_nxt     = S_EMIT;
        end else if (visited_r[root_v]) begin
          root_nxt = root_r + count_t'(1);
        end else begin
          visited_nxt[root_v] = 1'b1;
          on_path_nxt[root_v] = 1'b1;
          stk_req.wr_en       = 1'b1;
          stk_req.wr_addr     = '0;
          stk_req.wr_data     = root_v;
          depth_nxt           = count_t'(1);
          top_nxt             = root_v;
          adj_req.rd_en       = 1'b1;
          adj_req.rd_addr     = root_v;
          state_nxt           = S_EXPAND;
        end
      end

      // Row of the top vertex is here: detect back edge, push or pop
      S_EXPAND: begin
        if (hit) begin
          res_cycle_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else if (fresh != '0 && depth_r < count_t'(MAX_VERTICES)) begin
          visited_nxt[nxt_v] = 1'b1;
          on_path_nxt[nxt_v] = 1'b1;
          stk_req.wr_en      = 1'b1;
          stk_req.wr_addr    = depth_r[VTX_W-1:0];
          stk_req.wr_data    = nxt_v;
          depth_nxt          = depth_r + count_t'(1);
          top_nxt            = nxt_v;
          adj_req.rd_en      = 1'b1;
          adj_req.rd_addr    = nxt_v;
        end else begin
          on_path_nxt[top_r] = 1'b0;
          depth_nxt          = depth_r - count_t'(1);
          if (depth_r == count_t'(1)) begin
            root_nxt  = root_r + count_t'(1);
            state_nxt = S_ROOT;
          end else begin
            stk_req.rd_en   = 1'b1;
            stk_req.rd_addr = VTX_W'(depth_r - count_t'(2));
            state_nxt       = S_POPRD;
          end
        end
      end

      // New top arrives from the stack; fetch its row
      S_POPRD: begin
        top_nxt         = stk_rd_data;
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = stk_rd_data;
        state_nxt       = S_EXPAND;
      end

      // Hand the result to the output register once it is free
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_cycle_nxt  = res_cycle_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      visited_r   <= '0;
      on_path_r   <= '0;
      depth_r     <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      on_path_r   <= on_path_nxt;
      depth_r     <= depth_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    dst_r        <= dst_nxt;
    res_status_r <= res_status_nxt;
    res_cycle_r  <= res_cycle_nxt;
    out_status_r <= out_status_nxt;
    out_cycle_r  <= out_cycle_nxt;
  end

  // Path marks are always a subset of visited marks
  a_path_in_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (on_path_r & ~visited_r) == '0)
    else $error("on-path mark without visited mark");

  // Stack depth matches the number of vertices on the path while searching
  a_depth_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXPAND || state_r == S_POPRD) |->
      ($countones(on_path_r) == int'(depth_r)))
    else $error("stack depth out of step with path marks");

  // The vertex being expanded lies on the current path
  a_top_on_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXPAND) |-> on_path_r[top_r])
    else $error("expanded vertex not on path");

  // Stack never grows past its depth
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= count_t'(MAX_VERTICES))
    else $error("stack overflow");

endmodule

`default_nettype wire
